// ----- design/dps_pkg.sv -----
`timescale 1ns / 1ps

package dps_pkg;

    localparam int MAX_PROCS = 16;
    localparam int IDX_W = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int CNT_W = $clog2(MAX_PROCS + 1);

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    localparam logic [1:0] ST_ADDED  = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_SERVED = 2'd2;
    localparam logic [1:0] ST_IDLE   = 2'd3;

    localparam logic CFG_PRIORITY_BASE = 1'b0;
    localparam logic CFG_AGING_STEP    = 1'b1;

    localparam logic [7:0] PRIORITY_BASE_RST = 8'd20;
    localparam logic [3:0] AGING_STEP_RST    = 4'd2;

    localparam logic signed [10:0] PRIO_MIN = -11'sd1024;

    typedef struct packed {
        logic       cmd;
        logic [7:0] need_time;
    } item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [7:0]  process_id;
        logic [7:0]  remaining_time;
        logic        finished;
        logic [4:0]  active_count;
        logic [31:0] total_turnaround;
    } result_t;

    typedef struct packed {
        logic [7:0]         id;
        logic [7:0]         rtime;
        logic signed [10:0] prio;
    } entry_t;

endpackage

// ----- design/dynamic_priority_scheduler_core.sv -----
`timescale 1ns / 1ps

// Priority-sorted ready queue of up to MAX_PROCS processes. An add takes the next id and
// priority_base - need_time; a tick serves the head, ages it, and retires or requeues it.
// One shared signed comparator walks the queue from the head, one entry per cycle, to
// find the insert point; the shift and write happen in the cycle the walk stops. An add
// or a requeueing tick walks past the p entries ahead of the new slot (p is at most
// MAX_PROCS - 1) before the insert; a full add, an idle tick or a retiring tick skips
// the walk. item_stall is high from acceptance until the result is loaded into the output
// register, which holds it until the consumer takes the beat.
module dynamic_priority_scheduler_core (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  dps_pkg::item_t         item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output dps_pkg::result_t       result,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [1:0]             cfg_index,
    input  logic [7:0]             cfg_data
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_SCAN = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0]                state_reg, state_next;
    logic [7:0]                base_reg, base_next;
    logic [3:0]                step_reg, step_next;
    logic [dps_pkg::CNT_W-1:0] count_reg, count_next;
    logic [dps_pkg::CNT_W-1:0] pos_reg, pos_next;
    logic [7:0]                id_reg, id_next;
    logic [31:0]               sum_reg, sum_next;
    dps_pkg::entry_t           ins_reg, ins_next;
    dps_pkg::result_t          res_reg, res_next;
    dps_pkg::result_t          out_reg, out_next;
    logic                      out_valid_reg, out_valid_next;
    dps_pkg::entry_t           ent_reg [dps_pkg::MAX_PROCS];
    dps_pkg::entry_t           ent_next [dps_pkg::MAX_PROCS];

    logic                      accept;
    logic [dps_pkg::IDX_W-1:0] pos_idx;
    logic                      go_on;
    logic [32:0]               sum_wide;
    logic signed [11:0]        aged;
    logic [7:0]                head_time;

    assign item_stall   = (state_reg != S_IDLE);
    assign accept       = item_valid && !item_stall;
    assign cfg_ready    = 1'b1;
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    assign pos_idx  = pos_reg[dps_pkg::IDX_W-1:0];
    // shared compare: keep walking past entries of equal or higher priority
    assign go_on    = (pos_reg < count_reg) && (ent_reg[pos_idx].prio >= ins_reg.prio);
    assign sum_wide = {1'b0, sum_reg} + 33'(count_reg);
    assign aged     = {ent_reg[0].prio[10], ent_reg[0].prio} - $signed({8'd0, step_reg});
    assign head_time = (ent_reg[0].rtime != 8'd0) ? ent_reg[0].rtime - 8'd1 : 8'd0;

    always_comb
    begin
        state_next     = state_reg;
        base_next      = base_reg;
        step_next      = step_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        id_next        = id_reg;
        sum_next       = sum_reg;
        ins_next       = ins_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        ent_next       = ent_reg;

        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_valid && cfg_ready && cfg_index[1] == 1'b0)
        begin
            if (cfg_index[0] == dps_pkg::CFG_PRIORITY_BASE)
            begin
                base_next = cfg_data;
            end
            else
            begin
                step_next = cfg_data[3:0];
            end
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    res_next = '0;
                    pos_next = '0;
                    if (item.cmd == dps_pkg::CMD_ADD)
                    begin
                        res_next.process_id = id_reg;
                        if (count_reg >= dps_pkg::CNT_W'(dps_pkg::MAX_PROCS))
                        begin
                            res_next.status = dps_pkg::ST_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            res_next.status = dps_pkg::ST_ADDED;
                            ins_next.id     = id_reg;
                            ins_next.rtime  = item.need_time;
                            ins_next.prio   = $signed({3'd0, base_reg})
                                              - $signed({3'd0, item.need_time});
                            id_next         = id_reg + 8'd1;
                            state_next      = S_SCAN;
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status = dps_pkg::ST_IDLE;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        // pop the head
                        for (int k = 0; k < dps_pkg::MAX_PROCS - 1; k++)
                        begin
                            ent_next[k] = ent_reg[k+1];
                        end
                        count_next = count_reg - dps_pkg::CNT_W'(1);
                        sum_next   = sum_wide[32] ? 32'hFFFF_FFFF : sum_wide[31:0];
                        res_next.status         = dps_pkg::ST_SERVED;
                        res_next.process_id     = ent_reg[0].id;
                        res_next.remaining_time = head_time;
                        ins_next.id    = ent_reg[0].id;
                        ins_next.rtime = head_time;
                        ins_next.prio  = (aged[11] != aged[10]) ? dps_pkg::PRIO_MIN
                                                                : aged[10:0];
                        if (head_time == 8'd0)
                        begin
                            res_next.finished = 1'b1;
                            state_next        = S_DONE;
                        end
                        else
                        begin
                            state_next = S_SCAN;
                        end
                    end
                end
            end
            S_SCAN:
            begin
                if (go_on)
                begin
                    pos_next = pos_reg + dps_pkg::CNT_W'(1);
                end
                else
                begin
                    // open a slot at the insert point and drop the entry in
                    for (int k = 1; k < dps_pkg::MAX_PROCS; k++)
                    begin
                        if (dps_pkg::CNT_W'(k) > pos_reg)
                        begin
                            ent_next[k] = ent_reg[k-1];
                        end
                    end
                    ent_next[pos_idx] = ins_reg;
                    count_next        = count_reg + dps_pkg::CNT_W'(1);
                    state_next        = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    out_next                  = res_reg;
                    out_next.active_count     = 5'(count_reg);
                    out_next.total_turnaround = sum_reg;
                    out_valid_next            = 1'b1;
                    state_next                = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= dps_pkg::PRIORITY_BASE_RST;
            step_reg      <= dps_pkg::AGING_STEP_RST;
            count_reg     <= '0;
            id_reg        <= '0;
            sum_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            step_reg      <= step_next;
            count_reg     <= count_next;
            id_reg        <= id_next;
            sum_reg       <= sum_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg <= pos_next;
        ins_reg <= ins_next;
        res_reg <= res_next;
        out_reg <= out_next;
        ent_reg <= ent_next;
    end

endmodule
